@@ src/hcd_pkg.sv @@
`timescale 1ns / 1ps

package hcd_pkg;

    localparam int CODE_W   = 10;
    localparam int LETTER_W = 6;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;
    localparam int FIELD_W  = 32;
    localparam int TAB_W    = LETTER_W + 1;

    localparam int GROUP_LEN = 3;

    localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;
    localparam logic [BYTE_W-1:0] ASCII_NINE = 8'h39;

    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_CIPHER = 2'd1;
    localparam logic [1:0] MODE_QCODE  = 2'd2;
    localparam logic [1:0] MODE_QLET   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_LETTER  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_COUNT   = 2'd3;

    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = 2;
    localparam int OUT_CNT_W = 3;

    typedef struct packed {
        logic [1:0]          mode;
        logic [BYTE_W-1:0]   data_byte;
        logic [CODE_W-1:0]   code;
        logic [LETTER_W-1:0] letter;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [LETTER_W-1:0] out_letter;
        logic [CODE_W-1:0]   out_code;
        logic [FIELD_W-1:0]  count;
        logic [FIELD_W-1:0]  total_groups;
    } t_out_item;

    typedef struct packed {
        logic               done;
        logic               bad;
        logic [CODE_W-1:0]  value;
        logic [FIELD_W-1:0] total;
    } t_grp_info;

    function automatic logic [FIELD_W-1:0] clip32(input logic [63:0] v);
        return (v[63:32] != 32'd0) ? {FIELD_W{1'b1}} : v[31:0];
    endfunction

endpackage

@@ src/hcd_ram.sv @@
`timescale 1ns / 1ps

module hcd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/hcd_group.sv @@
`timescale 1ns / 1ps

module hcd_group
    import hcd_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_byte_fire,
    input  logic [BYTE_W-1:0] i_byte,
    output t_grp_info         o_info
);

    logic [CODE_W-1:0]      r_partial, n_partial;
    logic [1:0]             r_pos, n_pos;
    logic                   r_bad, n_bad;
    logic [COUNT_WIDTH-1:0] r_total, n_total;
    logic                   is_digit;
    logic [BYTE_W-1:0]      digit;
    logic [CODE_W-1:0]      acc;
    logic                   done;
    logic                   bad;

    always_comb begin
        is_digit = (i_byte >= ASCII_ZERO) && (i_byte <= ASCII_NINE);
        digit    = i_byte - ASCII_ZERO;
        acc      = {r_partial[6:0], 3'b000} + {r_partial[8:0], 1'b0} + {6'd0, digit[3:0]};
        done     = (r_pos == 2'(GROUP_LEN - 1));
        bad      = r_bad || !is_digit;
        n_partial = r_partial;
        n_pos     = r_pos;
        n_bad     = r_bad;
        n_total   = r_total;
        if (i_byte_fire) begin
            if (done) begin
                n_partial = '0;
                n_pos     = '0;
                n_bad     = 1'b0;
                if (!bad && !(&r_total)) begin
                    n_total = r_total + COUNT_WIDTH'(1);
                end
            end else begin
                n_partial = is_digit ? acc : r_partial;
                n_pos     = r_pos + 2'd1;
                n_bad     = bad;
            end
        end
        o_info.done  = done;
        o_info.bad   = bad;
        o_info.value = is_digit ? acc : r_partial;
        o_info.total = clip32(64'(n_total));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial <= '0;
            r_pos     <= '0;
            r_bad     <= 1'b0;
            r_total   <= '0;
        end else begin
            r_partial <= n_partial;
            r_pos     <= n_pos;
            r_bad     <= n_bad;
            r_total   <= n_total;
        end
    end

endmodule

@@ src/hcd_fifo.sv @@
`timescale 1ns / 1ps

module hcd_fifo
    import hcd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  t_out_item            i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_out_item            o_data,
    output logic [OUT_CNT_W-1:0] o_count
);

    t_out_item            r_mem [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] r_wr, r_rd;
    logic [OUT_CNT_W-1:0] r_cnt, n_cnt;
    logic                 pop;

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign o_count = r_cnt;
    assign pop     = o_valid && i_ready;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !pop) begin
            n_cnt = r_cnt + OUT_CNT_W'(1);
        end else if (pop && !i_push) begin
            n_cnt = r_cnt - OUT_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + OUT_PTR_W'(1);
            end
            if (pop) begin
                r_rd <= r_rd + OUT_PTR_W'(1);
            end
            r_cnt <= n_cnt;
        end
    end

endmodule

@@ src/homophonic_code_decoder_with_stats.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Handshake                Payload
// in        input      i_in_valid / o_in_ready  i_in_data  (t_in_item)
// out       output     o_out_valid / i_out_ready o_out_data (t_out_item)
//
// One item is accepted per cycle while o_in_ready is high, then staged in r_s1 and r_s2.
// The code-count memory is read and written back one stage later, and the letter-count
// memory one stage after that, each with a one-entry forwarding register.
// After reset a clearing pass over all CODE_ENTRIES addresses runs with o_in_ready low.
// Results queue in a four-entry buffer; o_in_ready drops while it and the items in
// flight hold four results.

module homophonic_code_decoder_with_stats
    import hcd_pkg::*;
#(
    parameter int CODE_ENTRIES = 1024,
    parameter int LETTERS      = 64,
    parameter int COUNT_WIDTH  = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    localparam int CA = $clog2(CODE_ENTRIES);
    localparam int LA = $clog2(LETTERS);

    localparam logic [1:0] K_GROUP = 2'd0;
    localparam logic [1:0] K_BAD   = 2'd1;
    localparam logic [1:0] K_QCODE = 2'd2;
    localparam logic [1:0] K_QLET  = 2'd3;

    typedef struct packed {
        logic                valid;
        logic [1:0]          kind;
        logic [CODE_W-1:0]   code;
        logic [CA-1:0]       caddr;
        logic                code_ok;
        logic [LETTER_W-1:0] letter;
        logic                letter_ok;
        logic [FIELD_W-1:0]  total;
    } t_s1;

    typedef struct packed {
        logic                valid;
        logic [STATUS_W-1:0] status;
        logic [LETTER_W-1:0] out_letter;
        logic [CODE_W-1:0]   out_code;
        logic [FIELD_W-1:0]  count;
        logic [FIELD_W-1:0]  total;
        logic                qlet;
        logic                lbump;
        logic [LA-1:0]       laddr;
    } t_s2;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        return (&v) ? v : v + COUNT_WIDTH'(1);
    endfunction

    logic                 r_clearing;
    logic [CA-1:0]        r_clr;
    logic                 fire;
    t_grp_info            grp;
    logic [OUT_CNT_W-1:0] fifo_cnt;
    logic [OUT_CNT_W-1:0] pending;
    t_s1                  r_s1, n_s1;
    t_s2                  r_s2, n_s2;
    t_out_item            res;

    logic                 tab_we;
    logic [CA-1:0]        tab_waddr;
    logic [TAB_W-1:0]     tab_wdata;
    logic [TAB_W-1:0]     tab_rdata;
    logic                 load_ok;

    logic                   cc_we, cc_bump;
    logic [CA-1:0]          cc_waddr, cc_raddr;
    logic [COUNT_WIDTH-1:0] cc_wdata, cc_rdata, cc_old, cc_new;
    logic                   r_cfw_v;
    logic [CA-1:0]          r_cfw_a;
    logic [COUNT_WIDTH-1:0] r_cfw_d;

    logic                   lc_we;
    logic [LA-1:0]          lc_waddr, lc_raddr;
    logic [COUNT_WIDTH-1:0] lc_wdata, lc_rdata, lc_old, lc_new;
    logic                   r_lfw_v;
    logic [LA-1:0]          r_lfw_a;
    logic [COUNT_WIDTH-1:0] r_lfw_d;

    logic                   hit;
    logic [LETTER_W-1:0]    tab_letter;
    logic                   tab_letter_ok;

    assign pending    = fifo_cnt + OUT_CNT_W'(r_s1.valid) + OUT_CNT_W'(r_s2.valid);
    assign o_in_ready = !r_clearing && (pending < OUT_CNT_W'(OUT_DEPTH));
    assign fire       = i_in_valid && o_in_ready;

    hcd_group #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_group (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_byte_fire(fire && (i_in_data.mode == MODE_CIPHER)),
        .i_byte     (i_in_data.data_byte),
        .o_info     (grp)
    );

    // Accept stage: table load, group completion and the first memory reads.
    always_comb begin
        load_ok = ({1'b0, i_in_data.code} < 11'(CODE_ENTRIES))
               && ({3'b000, i_in_data.letter} < 9'(LETTERS));
        n_s1 = '0;
        n_s1.letter    = i_in_data.letter;
        n_s1.letter_ok = ({3'b000, i_in_data.letter} < 9'(LETTERS));
        n_s1.total     = grp.total;
        unique case (i_in_data.mode)
            MODE_LOAD: begin
                n_s1.valid = 1'b0;
                n_s1.kind  = K_GROUP;
            end
            MODE_CIPHER: begin
                n_s1.valid = fire && grp.done;
                n_s1.kind  = grp.bad ? K_BAD : K_GROUP;
                n_s1.code  = grp.bad ? '0 : grp.value;
            end
            MODE_QCODE: begin
                n_s1.valid = fire;
                n_s1.kind  = K_QCODE;
                n_s1.code  = i_in_data.code;
            end
            MODE_QLET: begin
                n_s1.valid = fire;
                n_s1.kind  = K_QLET;
            end
            default: begin
                n_s1.valid = 1'b0;
            end
        endcase
        n_s1.caddr   = CA'(n_s1.code);
        n_s1.code_ok = ({1'b0, n_s1.code} < 11'(CODE_ENTRIES));
        cc_raddr     = (i_in_data.mode == MODE_QCODE) ? CA'(i_in_data.code) : CA'(grp.value);

        tab_we    = r_clearing || (fire && (i_in_data.mode == MODE_LOAD) && load_ok);
        tab_waddr = r_clearing ? r_clr : CA'(i_in_data.code);
        tab_wdata = r_clearing ? '0 : {1'b1, i_in_data.letter};
    end

    hcd_ram #(
        .WIDTH(TAB_W),
        .DEPTH(CODE_ENTRIES)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (tab_we),
        .i_waddr(tab_waddr),
        .i_wdata(tab_wdata),
        .i_raddr(CA'(grp.value)),
        .o_rdata(tab_rdata)
    );

    // Code-count stage: read-modify-write of the code counter, letter read.
    always_comb begin
        cc_old        = (r_cfw_v && (r_cfw_a == r_s1.caddr)) ? r_cfw_d : cc_rdata;
        cc_new        = sat_inc(cc_old);
        cc_bump       = r_s1.valid && (r_s1.kind == K_GROUP) && r_s1.code_ok;
        cc_we         = r_clearing || cc_bump;
        cc_waddr      = r_clearing ? r_clr : r_s1.caddr;
        cc_wdata      = r_clearing ? '0 : cc_new;
        hit           = tab_rdata[TAB_W-1] && r_s1.code_ok;
        tab_letter    = tab_rdata[LETTER_W-1:0];
        tab_letter_ok = ({3'b000, tab_letter} < 9'(LETTERS));

        n_s2 = '0;
        n_s2.valid = r_s1.valid;
        n_s2.total = r_s1.total;
        unique case (r_s1.kind)
            K_GROUP: begin
                n_s2.status     = hit ? ST_LETTER : ST_UNKNOWN;
                n_s2.out_letter = hit ? tab_letter : '0;
                n_s2.out_code   = r_s1.code;
                n_s2.lbump      = r_s1.valid && hit && tab_letter_ok;
                n_s2.laddr      = LA'(tab_letter);
            end
            K_BAD: begin
                n_s2.status = ST_BAD;
            end
            K_QCODE: begin
                n_s2.status   = ST_COUNT;
                n_s2.out_code = r_s1.code;
                n_s2.count    = r_s1.code_ok ? clip32(64'(cc_old)) : '0;
            end
            K_QLET: begin
                n_s2.status     = ST_COUNT;
                n_s2.out_letter = r_s1.letter;
                n_s2.qlet       = r_s1.letter_ok;
                n_s2.laddr      = LA'(r_s1.letter);
            end
            default: begin
                n_s2.status = ST_BAD;
            end
        endcase
        lc_raddr = n_s2.laddr;
    end

    hcd_ram #(
        .WIDTH(COUNT_WIDTH),
        .DEPTH(CODE_ENTRIES)
    ) u_code_counts (
        .i_clk  (i_clk),
        .i_we   (cc_we),
        .i_waddr(cc_waddr),
        .i_wdata(cc_wdata),
        .i_raddr(cc_raddr),
        .o_rdata(cc_rdata)
    );

    // Letter-count stage: read-modify-write of the letter counter, result push.
    always_comb begin
        lc_old   = (r_lfw_v && (r_lfw_a == r_s2.laddr)) ? r_lfw_d : lc_rdata;
        lc_new   = sat_inc(lc_old);
        lc_we    = (r_clearing && ({1'b0, r_clr} < (CA + 1)'(LETTERS)))
                || (r_s2.valid && r_s2.lbump);
        lc_waddr = r_clearing ? LA'(r_clr) : r_s2.laddr;
        lc_wdata = r_clearing ? '0 : lc_new;

        res.status       = r_s2.status;
        res.out_letter   = r_s2.out_letter;
        res.out_code     = r_s2.out_code;
        res.count        = r_s2.qlet ? clip32(64'(lc_old)) : r_s2.count;
        res.total_groups = r_s2.total;
    end

    hcd_ram #(
        .WIDTH(COUNT_WIDTH),
        .DEPTH(LETTERS)
    ) u_letter_counts (
        .i_clk  (i_clk),
        .i_we   (lc_we),
        .i_waddr(lc_waddr),
        .i_wdata(lc_wdata),
        .i_raddr(lc_raddr),
        .o_rdata(lc_rdata)
    );

    hcd_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (r_s2.valid),
        .i_data (res),
        .o_valid(o_out_valid),
        .i_ready(i_out_ready),
        .o_data (o_out_data),
        .o_count(fifo_cnt)
    );

    always_ff @(posedge i_clk) begin
        r_cfw_a <= r_s1.caddr;
        r_cfw_d <= cc_new;
        r_lfw_a <= r_s2.laddr;
        r_lfw_d <= lc_new;
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr      <= '0;
            r_s1       <= '0;
            r_s2       <= '0;
            r_cfw_v    <= 1'b0;
            r_lfw_v    <= 1'b0;
        end else begin
            r_s1 <= n_s1;
            r_s2 <= n_s2;
            if (r_clearing) begin
                r_clr <= r_clr + CA'(1);
                if (r_clr == CA'(CODE_ENTRIES - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            r_cfw_v <= cc_bump;
            r_lfw_v <= r_s2.valid && r_s2.lbump;
        end
    end

endmodule

@@ src/hcd_checker.sv @@
`timescale 1ns / 1ps

module hcd_checker
    import hcd_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data
);

    logic out_xfer;

    assign out_xfer = o_out_valid && i_out_ready;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("Result changed while stalled.");

    a_reset_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> (!o_in_ready && !o_out_valid))
        else $error("Block active right after reset.");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status == ST_BAD)) |->
        ((o_out_data.out_letter == '0) && (o_out_data.out_code == '0)
         && (o_out_data.count == '0)))
        else $error("Bad group result carries data.");

    a_count_only_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status != ST_COUNT)) |-> (o_out_data.count == '0))
        else $error("Nonzero count on a decode result.");

    a_total_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && $past(out_xfer)) |->
        (o_out_data.total_groups >= $past(o_out_data.total_groups)))
        else $error("Group total decreased between transfers.");

endmodule

bind homophonic_code_decoder_with_stats hcd_checker u_hcd_checker (.*);
